// File: hdl/mfhs_pkg.sv
// ----------------------------------------------------------------------------
// mfhs_pkg
// Shared types, constants and lookup tables for the MP3 frame header sync unit.
// ----------------------------------------------------------------------------
package mfhs_pkg;

	localparam int BYTE_W          = 8;
	localparam int OFF_OUT_W       = 16;
	localparam int LEN_W           = 14;
	localparam int BASE_W          = 11;
	localparam int KBPS_W          = 9;
	localparam int RATE_W          = 16;
	localparam int CH_W            = 2;
	localparam int OFFSET_BITS_DEF = 16;

	localparam logic [LEN_W-1:0] MAX_FRAME_RST = 14'd1536;
	localparam logic [LEN_W-1:0] MIN_FRAME     = 14'd24;

	// header queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// header field codes
	localparam logic [1:0] VER_MPEG25 = 2'd0;
	localparam logic [1:0] VER_RSVD   = 2'd1;
	localparam logic [1:0] VER_MPEG2  = 2'd2;
	localparam logic [1:0] VER_MPEG1  = 2'd3;
	localparam logic [1:0] LAYER_III  = 2'd1;
	localparam logic [1:0] SIDX_44K   = 2'd0;
	localparam logic [1:0] SIDX_48K   = 2'd1;
	localparam logic [1:0] SIDX_32K   = 2'd2;
	localparam logic [1:0] SIDX_RSVD  = 2'd3;
	localparam logic [3:0] BIDX_FREE  = 4'd0;
	localparam logic [3:0] BIDX_BAD   = 4'd15;
	localparam logic [1:0] MODE_MONO  = 2'd3;
	localparam logic [7:0] SYNC_BYTE  = 8'hFF;
	localparam logic [2:0] SYNC_TOP   = 3'b111;

	localparam logic [RATE_W-1:0] RATE_44K = 16'd44100;
	localparam logic [RATE_W-1:0] RATE_48K = 16'd48000;
	localparam logic [RATE_W-1:0] RATE_32K = 16'd32000;

	localparam logic [KBPS_W-1:0] KBPS_V1 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [KBPS_W-1:0] KBPS_V2 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	// frame length without padding, truncated
	localparam logic [BASE_W-1:0] LEN_V1_44K [16] = '{
		11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
		11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V1_48K [16] = '{
		11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
		11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V1_32K [16] = '{
		11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
		11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V2_44K [16] = '{
		11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
		11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V2_48K [16] = '{
		11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
		11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V2_32K [16] = '{
		11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
		11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V25_44K [16] = '{
		11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
		11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V25_48K [16] = '{
		11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
		11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0};
	localparam logic [BASE_W-1:0] LEN_V25_32K [16] = '{
		11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
		11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0};

	// candidate header passed from front to back
	typedef struct packed {
		logic [OFF_OUT_W-1:0] offset;
		logic [1:0]           version;
		logic [1:0]           sidx;
		logic [3:0]           bidx;
		logic                 pad;
		logic                 mono;
	} hdr_t;

	function automatic logic [BASE_W-1:0] frame_base(
		input logic [1:0] version,
		input logic [1:0] sidx,
		input logic [3:0] bidx
	);
		logic [BASE_W-1:0] r;
		r = '0;
		case (version)
			VER_MPEG1: begin
				case (sidx)
					SIDX_44K: r = LEN_V1_44K[bidx];
					SIDX_48K: r = LEN_V1_48K[bidx];
					SIDX_32K: r = LEN_V1_32K[bidx];
					default:  r = '0;
				endcase
			end
			VER_MPEG2: begin
				case (sidx)
					SIDX_44K: r = LEN_V2_44K[bidx];
					SIDX_48K: r = LEN_V2_48K[bidx];
					SIDX_32K: r = LEN_V2_32K[bidx];
					default:  r = '0;
				endcase
			end
			default: begin
				case (sidx)
					SIDX_44K: r = LEN_V25_44K[bidx];
					SIDX_48K: r = LEN_V25_48K[bidx];
					SIDX_32K: r = LEN_V25_32K[bidx];
					default:  r = '0;
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic logic [RATE_W-1:0] scaled_rate(
		input logic [1:0] version,
		input logic [1:0] sidx
	);
		logic [RATE_W-1:0] base;
		logic [RATE_W-1:0] r;
		case (sidx)
			SIDX_44K: base = RATE_44K;
			SIDX_48K: base = RATE_48K;
			SIDX_32K: base = RATE_32K;
			default:  base = '0;
		endcase
		case (version)
			VER_MPEG2:  r = base >> 1;
			VER_MPEG25: r = base >> 2;
			default:    r = base;
		endcase
		return r;
	endfunction

	function automatic logic [KBPS_W-1:0] bitrate(
		input logic [1:0] version,
		input logic [3:0] bidx
	);
		return (version == VER_MPEG1) ? KBPS_V1[bidx] : KBPS_V2[bidx];
	endfunction

endpackage

// File: hdl/mfhs_front.sv
// ----------------------------------------------------------------------------
// mfhs_front
// Byte window and counter; flags candidate headers and pushes them to the queue.
// ----------------------------------------------------------------------------
module mfhs_front #(
	parameter int OFFSET_BITS = mfhs_pkg::OFFSET_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mfhs_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         restart,
	input  logic                         q_ready,
	output logic                         q_push,
	output mfhs_pkg::hdr_t               q_data
);

	localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

	logic [mfhs_pkg::BYTE_W-1:0] win_q [3];
	logic [OFFSET_BITS-1:0]      cnt_q;

	logic [mfhs_pkg::BYTE_W-1:0] b0, b1, b2;
	logic [OFFSET_BITS-1:0]      cnt_eff;
	logic [OFFSET_BITS-1:0]      off;
	logic                        hdr_ok;
	logic                        take;

	assign in_ready = q_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		if (restart) begin
			b0      = '0;
			b1      = '0;
			b2      = '0;
			cnt_eff = '0;
		end else begin
			b0      = win_q[0];
			b1      = win_q[1];
			b2      = win_q[2];
			cnt_eff = cnt_q;
		end
	end

	always_comb begin
		hdr_ok = (cnt_eff >= OFFSET_BITS'(3)) &&
			(b0 == mfhs_pkg::SYNC_BYTE) &&
			(b1[7:5] == mfhs_pkg::SYNC_TOP) &&
			(b1[4:3] != mfhs_pkg::VER_RSVD) &&
			(b1[2:1] == mfhs_pkg::LAYER_III) &&
			(b2[7:4] != mfhs_pkg::BIDX_FREE) &&
			(b2[7:4] != mfhs_pkg::BIDX_BAD) &&
			(b2[3:2] != mfhs_pkg::SIDX_RSVD);
		off = (cnt_eff == CNT_MAX) ? CNT_MAX : cnt_eff - OFFSET_BITS'(3);
	end

	always_comb begin
		q_push         = take && hdr_ok;
		q_data.offset  = mfhs_pkg::OFF_OUT_W'(off);
		q_data.version = b1[4:3];
		q_data.sidx    = b2[3:2];
		q_data.bidx    = b2[7:4];
		q_data.pad     = b2[1];
		q_data.mono    = (data_byte[7:6] == mfhs_pkg::MODE_MONO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			cnt_q    <= '0;
		end else if (take) begin
			win_q[0] <= b1;
			win_q[1] <= b2;
			win_q[2] <= data_byte;
			cnt_q    <= (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
		end
	end

endmodule

// File: hdl/mfhs_queue.sv
// ----------------------------------------------------------------------------
// mfhs_queue
// Short FIFO of candidate headers between front and back.
// ----------------------------------------------------------------------------
module mfhs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfhs_pkg::hdr_t push_data,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output mfhs_pkg::hdr_t head
);

	mfhs_pkg::hdr_t                mem_q [mfhs_pkg::QUEUE_DEPTH];
	logic [mfhs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [mfhs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [mfhs_pkg::QCNT_W-1:0]   cnt_q;

	logic do_push, do_pop;

	assign ready   = (cnt_q != mfhs_pkg::QCNT_W'(mfhs_pkg::QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/mfhs_back.sv
// ----------------------------------------------------------------------------
// mfhs_back
// Table lookup, frame length check and output register.
// ----------------------------------------------------------------------------
module mfhs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mfhs_pkg::LEN_W-1:0]     cfg_wr_data,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  mfhs_pkg::hdr_t                 q_head,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mfhs_pkg::OFF_OUT_W-1:0] header_offset,
	output logic [mfhs_pkg::LEN_W-1:0]     frame_bytes,
	output logic [mfhs_pkg::KBPS_W-1:0]    bitrate_kbps,
	output logic [mfhs_pkg::RATE_W-1:0]    sample_rate_hz,
	output logic [mfhs_pkg::CH_W-1:0]      channel_count,
	output logic                           is_mpeg1
);

	logic [mfhs_pkg::LEN_W-1:0]     max_frame_q;
	logic                           out_valid_q;
	logic [mfhs_pkg::OFF_OUT_W-1:0] offset_q;
	logic [mfhs_pkg::LEN_W-1:0]     len_q;
	logic [mfhs_pkg::KBPS_W-1:0]    kbps_q;
	logic [mfhs_pkg::RATE_W-1:0]    rate_q;
	logic [mfhs_pkg::CH_W-1:0]      ch_q;
	logic                           mpeg1_q;

	logic [mfhs_pkg::LEN_W-1:0] len;
	logic                       len_ok;
	logic                       load;

	always_comb begin
		len = mfhs_pkg::LEN_W'(mfhs_pkg::frame_base(q_head.version, q_head.sidx,
			q_head.bidx)) + mfhs_pkg::LEN_W'(q_head.pad);
		len_ok = (len >= mfhs_pkg::MIN_FRAME) && (len <= max_frame_q);
		q_pop  = q_valid && (!out_valid_q || out_ready);
		load   = q_pop && len_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= mfhs_pkg::MAX_FRAME_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_frame_q <= cfg_wr_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			offset_q <= q_head.offset;
			len_q    <= len;
			kbps_q   <= mfhs_pkg::bitrate(q_head.version, q_head.bidx);
			rate_q   <= mfhs_pkg::scaled_rate(q_head.version, q_head.sidx);
			ch_q     <= q_head.mono ? 2'd1 : 2'd2;
			mpeg1_q  <= (q_head.version == mfhs_pkg::VER_MPEG1);
		end
	end

	assign out_valid      = out_valid_q;
	assign header_offset  = offset_q;
	assign frame_bytes    = len_q;
	assign bitrate_kbps   = kbps_q;
	assign sample_rate_hz = rate_q;
	assign channel_count  = ch_q;
	assign is_mpeg1       = mpeg1_q;

endmodule

// File: hdl/mp3_frame_header_sync_unit.sv
// ----------------------------------------------------------------------------
// mp3_frame_header_sync_unit
// MPEG Layer III frame header finder over a compressed byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one stream byte per item; restart marks
// the first byte of a new buffer and clears the window and byte count.
// Output channel (out_valid/out_ready): one item per valid header, giving its
// start offset (saturating), frame length, bitrate, sample rate, channel count
// and MPEG-1 flag. Bytes that complete no header give no output item.
// Config: cfg_wr_en/cfg_wr_data write the largest accepted frame length.
// Throughput: one byte per cycle, sustained while the output drains.
// A header completed by a taken byte is pushed into the queue as that byte is
// taken; the back then looks up the length tables and registers the item.
// A two-entry header queue separates front and back; when the receiver
// stalls the output register holds, the queue fills and in_ready drops.
// Reset: window and count clear, maximum frame length returns to 1536.
// ----------------------------------------------------------------------------
module mp3_frame_header_sync_unit #(
	parameter int OFFSET_BITS = mfhs_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mfhs_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mfhs_pkg::OFF_OUT_W-1:0] header_offset,
	output logic [mfhs_pkg::LEN_W-1:0]     frame_bytes,
	output logic [mfhs_pkg::KBPS_W-1:0]    bitrate_kbps,
	output logic [mfhs_pkg::RATE_W-1:0]    sample_rate_hz,
	output logic [mfhs_pkg::CH_W-1:0]      channel_count,
	output logic                           is_mpeg1,
	input  logic                           cfg_wr_en,
	input  logic [mfhs_pkg::LEN_W-1:0]     cfg_wr_data
);

	logic           q_push, q_ready, q_pop, q_valid;
	mfhs_pkg::hdr_t q_wdata, q_head;

	mfhs_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.restart   (restart),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	mfhs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	mfhs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_head         (q_head),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.header_offset  (header_offset),
		.frame_bytes    (frame_bytes),
		.bitrate_kbps   (bitrate_kbps),
		.sample_rate_hz (sample_rate_hz),
		.channel_count  (channel_count),
		.is_mpeg1       (is_mpeg1)
	);

endmodule

// File: hdl/mfhs_checker.sv
// ----------------------------------------------------------------------------
// mfhs_checker
// Port-level checks on the output items of the frame header sync unit.
// ----------------------------------------------------------------------------
module mfhs_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [mfhs_pkg::OFF_OUT_W-1:0] header_offset,
	input  logic [mfhs_pkg::LEN_W-1:0]     frame_bytes,
	input  logic [mfhs_pkg::KBPS_W-1:0]    bitrate_kbps,
	input  logic [mfhs_pkg::RATE_W-1:0]    sample_rate_hz,
	input  logic [mfhs_pkg::CH_W-1:0]      channel_count,
	input  logic                           is_mpeg1
);

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(header_offset) &&
		$stable(frame_bytes))
		else $error("output item changed while stalled");

	a_rate_ver: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_mpeg1 == (sample_rate_hz == mfhs_pkg::RATE_44K ||
		sample_rate_hz == mfhs_pkg::RATE_48K || sample_rate_hz == mfhs_pkg::RATE_32K))
		else $error("sample rate does not match version");

	a_kbps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_mpeg1 |-> bitrate_kbps >= 9'd32 && frame_bytes >= 14'd96)
		else $error("MPEG-1 bitrate or length out of range");

	a_ch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (channel_count == 2'd1 || channel_count == 2'd2) &&
		frame_bytes >= mfhs_pkg::MIN_FRAME)
		else $error("bad channel count or short frame");

endmodule

bind mp3_frame_header_sync_unit mfhs_checker u_mfhs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.header_offset  (header_offset),
	.frame_bytes    (frame_bytes),
	.bitrate_kbps   (bitrate_kbps),
	.sample_rate_hz (sample_rate_hz),
	.channel_count  (channel_count),
	.is_mpeg1       (is_mpeg1)
);
